// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared definitions for the double-ended queue
// Word width, default depth, operation and status codes.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int WORD_W    = 32;
    localparam int DEPTH_DEF = 64;

    // operation codes
    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_SEARCH     = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

// ===== rtl/deq_store.sv =====
// ----------------------------------------------------------------------------
// deq_store: entry storage for the double-ended queue
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_store
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WORD_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WORD_W-1:0]        rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words
// Ring buffer with front/back indices, shadowed end words and a scan engine.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction: opcode and
//   data_word. Output channel (out_valid/out_ready) returns one result per
//   input transaction: popped value, found flag, status, front/back words
//   and occupancy after the operation.
//   One transaction is in work at a time; in_ready is high only while the
//   sequencer is idle. From accept, the sequencer steps through its states:
//     push            EXEC, DONE
//     pop             EXEC, FETCH, DONE (FETCH only if entries remain)
//     search          EXEC, SCAN for each held entry up to a match, DONE
//     other opcodes   EXEC, DONE
//   The next transaction is accepted in the cycle after the result is
//   registered. The search walks the storage one entry per cycle through
//   its single read port; the front and back words are held in shadow
//   registers, so pushes need no read and pops one read for the new end.
//   A full result register that the receiver stalls holds the sequencer
//   in its final state until the slot frees up; nothing is dropped.
//   Reset empties the queue (front index 0, occupancy 0). Storage content
//   is not cleared; entries are read only after being written.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0]                       opcode,
    input  logic signed [WORD_W-1:0]         data_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [WORD_W-1:0]         popped_value,
    output logic                             found,
    output logic [1:0]                       status,
    output logic signed [WORD_W-1:0]         front_word,
    output logic signed [WORD_W-1:0]         back_word,
    output logic [$clog2(DEPTH+1)-1:0]       occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] IDX_LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_ONE   = CW'(1);

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_FETCH = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    // ring index step with wrap (DEPTH need not be a power of two)
    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
        return (idx == IDX_LAST) ? '0 : idx + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] idx);
        return (idx == '0) ? IDX_LAST : idx - AW'(1);
    endfunction

    state_t              state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [AW-1:0]       front_idx_reg, front_idx_next;
    logic [AW-1:0]       back_idx_reg, back_idx_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [WORD_W-1:0]   front_word_reg, front_word_next;
    logic [WORD_W-1:0]   back_word_reg, back_word_next;
    logic [WORD_W-1:0]   popped_reg, popped_next;
    logic                found_reg, found_next;
    logic [1:0]          status_reg, status_next;
    logic [AW-1:0]       scan_addr_reg, scan_addr_next;
    logic [CW-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                fetch_back_reg, fetch_back_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_popped_reg, out_popped_next;
    logic                out_found_reg, out_found_next;
    logic [1:0]          out_status_reg, out_status_next;
    logic [WORD_W-1:0]   out_front_reg, out_front_next;
    logic [WORD_W-1:0]   out_back_reg, out_back_next;
    logic [CW-1:0]       out_count_reg, out_count_next;

    // storage port signals
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [WORD_W-1:0]   rd_data;

    logic                is_full;
    logic                is_empty;
    logic [AW-1:0]       front_inc, front_dec, back_inc, back_dec;

    deq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (word_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign is_full   = (count_reg == CNT_FULL);
    assign is_empty  = (count_reg == '0);
    assign front_inc = idx_inc(front_idx_reg);
    assign front_dec = idx_dec(front_idx_reg);
    assign back_inc  = idx_inc(back_idx_reg);
    assign back_dec  = idx_dec(back_idx_reg);

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign popped_value = $signed(out_popped_reg);
    assign found        = out_found_reg;
    assign status       = out_status_reg;
    assign front_word   = $signed(out_front_reg);
    assign back_word    = $signed(out_back_reg);
    assign occupancy    = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        word_next       = word_reg;
        front_idx_next  = front_idx_reg;
        back_idx_next   = back_idx_reg;
        count_next      = count_reg;
        front_word_next = front_word_reg;
        back_word_next  = back_word_reg;
        popped_next     = popped_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        scan_addr_next  = scan_addr_reg;
        scan_cnt_next   = scan_cnt_reg;
        fetch_back_next = fetch_back_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        out_popped_next = out_popped_reg;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;
        out_count_next  = out_count_reg;

        wr_en   = 1'b0;
        wr_addr = back_inc;
        rd_en   = 1'b0;
        rd_addr = scan_addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = opcode;
                    word_next   = data_word;
                    popped_next = '0;
                    found_next  = 1'b0;
                    status_next = ST_DONE;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (op_reg)
                    OP_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            wr_addr        = back_inc;
                            back_idx_next  = back_inc;
                            count_next     = count_reg + CW'(1);
                            back_word_next = word_reg;
                            if (is_empty)
                            begin
                                front_word_next = word_reg;
                            end
                        end
                    end

                    OP_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = front_dec;
                            front_idx_next  = front_dec;
                            count_next      = count_reg + CW'(1);
                            front_word_next = word_reg;
                            if (is_empty)
                            begin
                                back_word_next = word_reg;
                            end
                        end
                    end

                    OP_POP_FRONT:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            popped_next    = front_word_reg;
                            front_idx_next = front_inc;
                            count_next     = count_reg - CW'(1);
                            if (count_reg != CNT_ONE)
                            begin
                                // new front word comes from storage
                                rd_en           = 1'b1;
                                rd_addr         = front_inc;
                                fetch_back_next = 1'b0;
                                state_next      = S_FETCH;
                            end
                        end
                    end

                    OP_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            popped_next   = back_word_reg;
                            back_idx_next = back_dec;
                            count_next    = count_reg - CW'(1);
                            if (count_reg != CNT_ONE)
                            begin
                                rd_en           = 1'b1;
                                rd_addr         = back_dec;
                                fetch_back_next = 1'b1;
                                state_next      = S_FETCH;
                            end
                        end
                    end

                    OP_SEARCH:
                    begin
                        if (!is_empty)
                        begin
                            // prime the read pipe with the front entry
                            rd_en          = 1'b1;
                            rd_addr        = front_idx_reg;
                            scan_addr_next = front_inc;
                            scan_cnt_next  = count_reg;
                            state_next     = S_SCAN;
                        end
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_FETCH:
            begin
                if (fetch_back_reg)
                begin
                    back_word_next = rd_data;
                end
                else
                begin
                    front_word_next = rd_data;
                end
                state_next = S_DONE;
            end

            S_SCAN:
            begin
                // compare the entry read last cycle, read the next one
                rd_en          = 1'b1;
                rd_addr        = scan_addr_reg;
                scan_addr_next = idx_inc(scan_addr_reg);
                scan_cnt_next  = scan_cnt_reg - CW'(1);
                if (rd_data == word_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (scan_cnt_reg == CNT_ONE)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_popped_next = popped_reg;
                    out_found_next  = found_reg;
                    out_status_next = status_reg;
                    out_front_next  = is_empty ? '0 : front_word_reg;
                    out_back_next   = is_empty ? '0 : back_word_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_idx_reg <= '0;
            back_idx_reg  <= IDX_LAST;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_idx_reg <= front_idx_next;
            back_idx_reg  <= back_idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        word_reg        <= word_next;
        front_word_reg  <= front_word_next;
        back_word_reg   <= back_word_next;
        popped_reg      <= popped_next;
        found_reg       <= found_next;
        status_reg      <= status_next;
        scan_addr_reg   <= scan_addr_next;
        scan_cnt_reg    <= scan_cnt_next;
        fetch_back_reg  <= fetch_back_next;
        out_popped_reg  <= out_popped_next;
        out_found_reg   <= out_found_next;
        out_status_reg  <= out_status_next;
        out_front_reg   <= out_front_next;
        out_back_reg    <= out_back_next;
        out_count_reg   <= out_count_next;
    end

    // occupancy never exceeds the ring size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("occupancy above depth");

    // an empty ring keeps back one slot behind front
    a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
        is_empty |-> back_idx_reg == idx_dec(front_idx_reg))
        else $error("ring indices out of step on empty queue");

    // a push that fits grows the queue by exactly one
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && !is_full &&
         (op_reg == OP_PUSH_BACK || op_reg == OP_PUSH_FRONT))
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not grow occupancy");

    // a full-drop result reports a full queue
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_FULL) |-> out_count_reg == CNT_FULL)
        else $error("full status with spare room");

    // an empty-pop result reports nothing held and nothing popped
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_EMPTY)
        |-> (out_count_reg == '0 && out_popped_reg == '0))
        else $error("empty status inconsistent");

endmodule

// ===== sim/double_ended_queue_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_tb: self-checking bench for the bounded deque
// Drives push/pop/search transactions through the valid/ready input channel,
// predicts every result with a ring-buffer model of its own and compares each
// result transaction field by field. A directed table comes first. Random
// bursts follow that fill, drain, mix and scan the queue under varying
// sender and receiver idling.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int OCC_W      = $clog2(DEPTH + 1);
    localparam int N_RAND     = 1700;
    localparam int HOLD_LEN   = 200;       // long receiver hold-off, in cycles
    localparam int HOLD_AT    = 250;       // random transaction index of hold-off
    localparam int PAUSE_AT   = 900;       // sender waits for a full drain here
    localparam int DRAIN_LEN  = DEPTH + 16;
    localparam int IDLE_LIMIT = 2000;      // cycles with no transaction at all
    localparam int N_REPORT   = 10;

    // opcodes with no operation behind them
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic [WORD_W-1:0] popped;
        logic              found;
        logic [1:0]        status;
        logic [WORD_W-1:0] front;
        logic [WORD_W-1:0] back;
        logic [OCC_W-1:0]  occ;
    } deq_result_t;

    // one row of the directed table; want is used only where typed is set
    typedef struct packed {
        logic [2:0]        op;
        logic [WORD_W-1:0] word;
        logic              typed;
        deq_result_t       want;
    } dir_row_t;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_SCAN} burst_mode_t;

    localparam int N_DIR = 23;

    // Directed walk: empty-queue pops and search, undefined opcodes, the two
    // word extremes at both ends, searches that hit and miss, draining back to
    // empty, an empty pop once more, then two pushes, a hit search and a drain.
    dir_row_t dir_tab [N_DIR] = '{
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1,
          '{32'h0, 1'b0, ST_EMPTY, 32'h0, 32'h0, 7'd0}},
        '{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1,
          '{32'h0, 1'b0, ST_EMPTY, 32'h0, 32'h0, 7'd0}},
        '{OP_SEARCH,     32'h0000_0000, 1'b1,
          '{32'h0, 1'b0, ST_DONE, 32'h0, 32'h0, 7'd0}},
        '{OP_RSVD5,      32'hDEAD_BEEF, 1'b1,
          '{32'h0, 1'b0, ST_DONE, 32'h0, 32'h0, 7'd0}},
        '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1,
          '{32'h0, 1'b0, ST_DONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd1}},
        '{OP_PUSH_FRONT, 32'h8000_0000, 1'b1,
          '{32'h0, 1'b0, ST_DONE, 32'h8000_0000, 32'h7FFF_FFFF, 7'd2}},
        '{OP_PUSH_BACK,  32'h0000_0000, 1'b0, '0},
        '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_SEARCH,     32'h8000_0000, 1'b0, '0},
        '{OP_SEARCH,     32'h1234_5678, 1'b0, '0},
        '{OP_SEARCH,     32'h0000_0000, 1'b0, '0},
        '{OP_RSVD6,      32'h0000_0000, 1'b0, '0},
        '{OP_POP_BACK,   32'h1111_1111, 1'b0, '0},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, '0},
        '{OP_RSVD7,      32'hFFFF_FFFF, 1'b0, '0},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, '0},
        '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0},
        '{OP_POP_BACK,   32'h0000_0000, 1'b1,
          '{32'h0, 1'b0, ST_EMPTY, 32'h0, 32'h0, 7'd0}},
        '{OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, '0},
        '{OP_PUSH_BACK,  32'h5555_5555, 1'b0, '0},
        '{OP_SEARCH,     32'h5555_5555, 1'b0, '0},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, '0},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, '0}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [2:0]               opcode;
    logic signed [WORD_W-1:0] data_word;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [WORD_W-1:0] popped_value;
    logic                     found;
    logic [1:0]               status;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] back_word;
    logic [OCC_W-1:0]         occupancy;

    // predictor state: ring of held words, front position and count
    logic [WORD_W-1:0] ring_words [DEPTH];
    int unsigned       ring_front;
    int unsigned       ring_count;

    deq_result_t       pending_results [$];
    int                err_count;
    int                idle_pct;     // chance per cycle that the sender idles
    int                stall_pct;    // chance per cycle that the receiver stalls
    bit                hold_req;     // sender asks the receiver for a hold-off

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .data_word   (data_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .popped_value(popped_value),
        .found       (found),
        .status      (status),
        .front_word  (front_word),
        .back_word   (back_word),
        .occupancy   (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one operation to the predictor ring and returns the result it
    // should produce. Front pushes and pops move the front index around the ring.
    function automatic deq_result_t deq_predict(input logic [2:0] op,
                                                input logic [WORD_W-1:0] w);
        deq_result_t r;
        int unsigned k;
        r = '0;
        case (op)
            OP_PUSH_BACK:
            begin
                if (ring_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    ring_words[(ring_front + ring_count) % DEPTH] = w;
                    ring_count++;
                end
            end
            OP_PUSH_FRONT:
            begin
                if (ring_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    ring_front = (ring_front + DEPTH - 1) % DEPTH;
                    ring_words[ring_front] = w;
                    ring_count++;
                end
            end
            OP_POP_FRONT:
            begin
                if (ring_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.popped   = ring_words[ring_front];
                    ring_front = (ring_front + 1) % DEPTH;
                    ring_count--;
                end
            end
            OP_POP_BACK:
            begin
                if (ring_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.popped = ring_words[(ring_front + ring_count - 1) % DEPTH];
                    ring_count--;
                end
            end
            OP_SEARCH:
            begin
                for (k = 0; k < ring_count; k++)
                    if (ring_words[(ring_front + k) % DEPTH] == w)
                        r.found = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (ring_count != 0)
        begin
            r.front = ring_words[ring_front];
            r.back  = ring_words[(ring_front + ring_count - 1) % DEPTH];
        end
        r.occ = OCC_W'(ring_count);
        return r;
    endfunction

    // Presents one input transaction. Entered and left at a falling edge;
    // the expectation is queued at the edge where the transaction is taken.
    task automatic offer(input logic [2:0] op, input logic [WORD_W-1:0] w,
                         input logic typed, input deq_result_t want);
        deq_result_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        r = deq_predict(op, w);
        pending_results.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    // Operation mix per burst kind; a few undefined opcodes everywhere.
    function automatic logic [2:0] pick_op(input burst_mode_t mode);
        int r;
        int p_push;
        int p_pop;
        r = $urandom_range(99);
        case (mode)
            MODE_FILL:  begin p_push = 85; p_pop = 7;  end
            MODE_DRAIN: begin p_push = 7;  p_pop = 85; end
            MODE_MIX:   begin p_push = 40; p_pop = 40; end
            default:    begin p_push = 20; p_pop = 20; end
        endcase
        if (r < 3)
            return 3'(OP_RSVD5 + $urandom_range(2));
        else if (r < 3 + p_push)
            return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else if (r < 3 + p_push + p_pop)
            return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
        else
            return OP_SEARCH;
    endfunction

    // Word mix: full-range random, extremes, a small pool so that duplicates
    // happen, and a word already held so that searches hit anywhere.
    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(99);
        if (r < 45 || (r >= 80 && ring_count == 0))
            return $urandom;
        else if (r < 65)
        begin
            case ($urandom_range(4))
                0:       return 32'h0000_0000;
                1:       return 32'h0000_0001;
                2:       return 32'hFFFF_FFFF;
                3:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        else if (r < 80)
            return $urandom_range(15);
        else
            return ring_words[(ring_front + $urandom_range(ring_count - 1)) % DEPTH];
    endfunction

    // Sender: reset, directed table, random bursts, then the final drain.
    initial
    begin
        int          i;
        int          n;
        int          j;
        int          len;
        burst_mode_t mode;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = OP_PUSH_BACK;
        data_word  = '0;
        err_count  = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_req   = 1'b0;
        ring_front = 0;
        ring_count = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < N_DIR; i++)
            offer(dir_tab[i].op, dir_tab[i].word, dir_tab[i].typed, dir_tab[i].want);

        n = 0;
        while (n < N_RAND)
        begin
            mode = burst_mode_t'($urandom_range(3));
            len  = (mode == MODE_FILL) ? $urandom_range(60, 120) : $urandom_range(20, 80);
            for (j = 0; j < len && n < N_RAND; j++)
            begin
                // idling phase rotates every hundred transactions
                case ((n / 100) % 4)
                    0:       begin idle_pct = 0;  stall_pct = 0;  end
                    1:       begin idle_pct = 58; stall_pct = 0;  end
                    2:       begin idle_pct = 0;  stall_pct = 58; end
                    default: begin idle_pct = 12; stall_pct = 12; end
                endcase
                if (n == HOLD_AT)
                    hold_req = 1'b1;
                if (n == PAUSE_AT)
                begin
                    // sender goes quiet until every result is back
                    in_valid <= 1'b0;
                    do
                        @(negedge clk);
                    while (pending_results.size() != 0);
                end
                offer(pick_op(mode), pick_word(), 1'b0, '0);
                n++;
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_LEN) @(posedge clk);
        if (err_count == 0)
            $display("double_ended_queue_tb OK");
        else
            $display("double_ended_queue_tb NOT OK");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request so that the
    // result register backs up and the input channel stalls.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker: every output transaction against the oldest expectation.
    always @(posedge clk)
    begin
        deq_result_t got;
        deq_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{popped_value, found, status, front_word, back_word, occupancy};
            if (pending_results.size() == 0)
            begin
                err_count++;
                if (err_count <= N_REPORT)
                    $display("unexpected result transaction: %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    err_count++;
                    if (err_count <= N_REPORT)
                    begin
                        $display("mismatch: popped exp %h got %h, found exp %b got %b",
                                 want.popped, got.popped, want.found, got.found);
                        $display("  status exp %0d got %0d, front exp %h got %h",
                                 want.status, got.status, want.front, got.front);
                        $display("  back exp %h got %h, occupancy exp %0d got %0d",
                                 want.back, got.back, want.occ, got.occ);
                    end
                end
            end
        end
    end

    // Watchdog: too long without a transaction on either channel.
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("double_ended_queue_tb NOT OK");
            $finish;
        end
    end

endmodule
